### rtl/mst_pkg.sv
// Shared types and constants for the multi-slot timer bank.
package mst_pkg;

  localparam int unsigned DeadlineW  = 32;
  localparam int unsigned ReloadW    = 31;
  localparam int unsigned SlotW      = 4;
  localparam int unsigned MaxResults = 16;
  localparam int unsigned CntW       = $clog2(MaxResults + 1);

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_START  = 2'd1,
    CMD_CHANGE = 2'd2,
    CMD_STOP   = 2'd3
  } cmd_e;

  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_EXPIRY = 1'b1
  } kind_e;

  typedef enum logic {
    STAT_OK     = 1'b0,
    STAT_ACTIVE = 1'b1
  } stat_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN
  } state_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [SlotW-1:0]   slot;
    logic [ReloadW-1:0] timeout;
    logic [ReloadW-1:0] repeat_req;
  } req_t;

  typedef struct packed {
    logic             kind;
    logic [SlotW-1:0] slot_id;
    logic             status;
    logic             last;
  } rsp_t;

  typedef struct packed {
    logic [DeadlineW-1:0] deadline;
    logic [ReloadW-1:0]   reload;
  } mem_word_t;

endpackage

### rtl/multi_slot_software_timer_top.sv
// Top level of the multi-slot timer bank: controller, slot memory and output register.
//
//   channel   direction  handshake                  payload
//   request   in         req_valid_i / req_ready_o  req_i (cmd, slot, timeout, repeat_req)
//   result    out        rsp_valid_o / rsp_ready_i  rsp_o (kind, slot_id, status, last)
//
// Start, change and stop each give one status result.
// A tick is accepted, then the scan reads one slot per cycle from the slot memory unless
// a stalled result holds it, evaluates each registered read, and ends in the drain state.
// A stalled result output holds the scan on its next expiry; requests wait until idle.
// Reset clears the tick count and all armed flags at once; memory contents need no clear.
module multi_slot_software_timer_top import mst_pkg::*; #(
  parameter int unsigned NUM_TIMERS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  req_t req_i,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  output rsp_t rsp_o
);

  logic res_valid;
  logic res_ready;
  rsp_t res;
  logic out_valid_q, out_valid_d;
  rsp_t out_q, out_d;

  mst_ctrl #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || rsp_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_ready) begin
      out_valid_d = res_valid;
      if (res_valid) begin
        out_d = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;

endmodule

### rtl/mst_mem.sv
// Slot memory holding deadline and reload words, one write and one registered read port.
module mst_mem import mst_pkg::*; #(
  parameter int unsigned Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  mem_word_t                              wdata_i,
  input  logic                                   re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output mem_word_t                              rdata_o
);

  mem_word_t mem_q [Depth];
  mem_word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/mst_ctrl.sv
// Command handling, tick count, armed flags and the expiry scan over the slot memory.
module mst_ctrl import mst_pkg::*; #(
  parameter int unsigned NUM_TIMERS = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  req_valid_i,
  output logic  req_ready_o,
  input  req_t  req_i,
  output logic  res_valid_o,
  input  logic  res_ready_i,
  output rsp_t  res_o
);

  localparam int unsigned IdxW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_TIMERS - 1);
  localparam logic [IdxW:0]   NumIdx  = (IdxW + 1)'(NUM_TIMERS);
  localparam logic [CntW-1:0] CapCnt  = CntW'(MaxResults - 1);

  state_e                 state_q, state_d;
  logic [DeadlineW-1:0]   now_q, now_d;
  logic [NUM_TIMERS-1:0]  armed_q, armed_d;
  logic [IdxW:0]          rd_idx_q, rd_idx_d;
  logic                   ev_vld_q, ev_vld_d;
  logic [IdxW-1:0]        ev_idx_q, ev_idx_d;
  logic                   pend_vld_q, pend_vld_d;
  logic [IdxW-1:0]        pend_idx_q, pend_idx_d;
  logic [CntW-1:0]        cnt_q, cnt_d;

  logic                   mem_we;
  logic [IdxW-1:0]        mem_waddr;
  mem_word_t              mem_wdata;
  logic                   mem_re;
  mem_word_t              ev_rd;

  logic [IdxW-1:0]        cmd_idx;
  logic                   slot_in_range;
  logic [DeadlineW-1:0]   diff;
  logic                   reached;
  logic                   hit;
  logic                   stall;
  logic                   done;

  mst_mem #(
    .Depth (NUM_TIMERS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (rd_idx_q[IdxW-1:0]),
    .rdata_o (ev_rd)
  );

  assign cmd_idx       = IdxW'(req_i.slot);
  assign slot_in_range = 32'(req_i.slot) < 32'(NUM_TIMERS);
  assign diff          = ev_rd.deadline - now_q;
  assign reached       = (diff == '0) || diff[DeadlineW-1];
  assign hit           = (state_q == S_SCAN) && ev_vld_q && armed_q[ev_idx_q] && reached;
  assign stall         = hit && pend_vld_q && !res_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      now_q      <= '0;
      armed_q    <= '0;
      rd_idx_q   <= '0;
      ev_vld_q   <= 1'b0;
      ev_idx_q   <= '0;
      pend_vld_q <= 1'b0;
      pend_idx_q <= '0;
      cnt_q      <= '0;
    end else begin
      state_q    <= state_d;
      now_q      <= now_d;
      armed_q    <= armed_d;
      rd_idx_q   <= rd_idx_d;
      ev_vld_q   <= ev_vld_d;
      ev_idx_q   <= ev_idx_d;
      pend_vld_q <= pend_vld_d;
      pend_idx_q <= pend_idx_d;
      cnt_q      <= cnt_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    now_d       = now_q;
    armed_d     = armed_q;
    rd_idx_d    = rd_idx_q;
    ev_vld_d    = ev_vld_q;
    ev_idx_d    = ev_idx_q;
    pend_vld_d  = pend_vld_q;
    pend_idx_d  = pend_idx_q;
    cnt_d       = cnt_q;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    mem_we      = 1'b0;
    mem_waddr   = ev_idx_q;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    done        = 1'b0;

    case (state_q)
      S_IDLE: begin
        req_ready_o = res_ready_i;
        if (req_valid_i && res_ready_i) begin
          if (req_i.cmd == CMD_TICK) begin
            now_d      = now_q + 1'b1;
            state_d    = S_SCAN;
            rd_idx_d   = '0;
            ev_vld_d   = 1'b0;
            pend_vld_d = 1'b0;
            cnt_d      = '0;
          end else begin
            res_valid_o    = 1'b1;
            res_o.kind     = KIND_STATUS;
            res_o.slot_id  = req_i.slot;
            res_o.status   = STAT_OK;
            res_o.last     = 1'b1;
            mem_waddr      = cmd_idx;
            mem_wdata.deadline = now_q + {1'b0, req_i.timeout};
            if (slot_in_range) begin
              case (req_i.cmd)
                CMD_START: begin
                  if (armed_q[cmd_idx]) begin
                    res_o.status = STAT_ACTIVE;
                  end else begin
                    mem_we           = 1'b1;
                    mem_wdata.reload = req_i.repeat_req;
                    armed_d[cmd_idx] = 1'b1;
                  end
                end
                CMD_CHANGE: begin
                  mem_we           = 1'b1;
                  mem_wdata.reload = '0;
                  if (armed_q[cmd_idx]) begin
                    res_o.status = STAT_ACTIVE;
                  end
                  armed_d[cmd_idx] = 1'b1;
                end
                CMD_STOP: begin
                  armed_d[cmd_idx] = 1'b0;
                end
                default: ;
              endcase
            end
          end
        end
      end

      S_SCAN: begin
        if (!stall) begin
          if (hit) begin
            cnt_d      = cnt_q + 1'b1;
            pend_vld_d = 1'b1;
            pend_idx_d = ev_idx_q;
            if (pend_vld_q) begin
              res_valid_o   = 1'b1;
              res_o.kind    = KIND_EXPIRY;
              res_o.slot_id = SlotW'(pend_idx_q);
              res_o.status  = STAT_OK;
              res_o.last    = 1'b0;
            end
            if (ev_rd.reload == '0) begin
              armed_d[ev_idx_q] = 1'b0;
            end else begin
              mem_we             = 1'b1;
              mem_waddr          = ev_idx_q;
              mem_wdata.deadline = now_q + {1'b0, ev_rd.reload};
              mem_wdata.reload   = ev_rd.reload;
            end
          end
          done = (ev_vld_q && (ev_idx_q == LastIdx)) || (hit && (cnt_q == CapCnt));
          if (done) begin
            state_d  = S_DRAIN;
            ev_vld_d = 1'b0;
          end else if (rd_idx_q < NumIdx) begin
            mem_re   = 1'b1;
            ev_vld_d = 1'b1;
            ev_idx_d = rd_idx_q[IdxW-1:0];
            rd_idx_d = rd_idx_q + 1'b1;
          end else begin
            ev_vld_d = 1'b0;
          end
        end
      end

      S_DRAIN: begin
        if (pend_vld_q) begin
          res_valid_o   = 1'b1;
          res_o.kind    = KIND_EXPIRY;
          res_o.slot_id = SlotW'(pend_idx_q);
          res_o.status  = STAT_OK;
          res_o.last    = 1'b1;
          if (res_ready_i) begin
            pend_vld_d = 1'b0;
            state_d    = S_IDLE;
          end
        end else begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

### test/tb_multi_slot_software_timer_top.sv
// Self-checking testbench for the multi-slot timer bank: directed and random requests.
module tb_multi_slot_software_timer_top;
  import mst_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumSlots   = 16;
  localparam int QuietLimit = 2000;
  localparam int TailCycles = 60;

  class timer_bank_board;
    logic [DeadlineW-1:0] tick_now;
    bit                   armed [NumSlots];
    logic [DeadlineW-1:0] due_at [NumSlots];
    logic [ReloadW-1:0]   period [NumSlots];
    rsp_t                 pending_events_q[$];
    int                   failures;
    int                   requests;
    int                   ticks;
    int                   expiries;
    int                   busy_reports;
    int                   results_seen;

    function new();
      tick_now = '0;
      foreach (armed[i]) begin
        armed[i]  = 1'b0;
        due_at[i] = '0;
        period[i] = '0;
      end
      failures     = 0;
      requests     = 0;
      ticks        = 0;
      expiries     = 0;
      busy_reports = 0;
      results_seen = 0;
    endfunction

    function bit is_due(logic [DeadlineW-1:0] when);
      logic [DeadlineW-1:0] diff;
      diff = when - tick_now;
      return diff == '0 || diff[DeadlineW-1];
    endfunction

    function string fmt(rsp_t r);
      return $sformatf("kind=%0d slot_id=%0d status=%0d last=%0d",
                       r.kind, r.slot_id, r.status, r.last);
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= 10) $display("mismatch: %s", msg);
    endfunction

    function int pending();
      return pending_events_q.size();
    endfunction

    function void note_request(req_t r);
      rsp_t batch[$];
      rsp_t e;
      int   s;
      requests++;
      s = int'(r.slot);
      if (cmd_e'(r.cmd) == CMD_TICK) begin
        ticks++;
        tick_now = tick_now + 1;
        for (int i = 0; i < NumSlots; i++) begin
          if (batch.size() < MaxResults && armed[i] && is_due(due_at[i])) begin
            if (period[i] == '0) armed[i] = 1'b0;
            else due_at[i] = tick_now + {1'b0, period[i]};
            e.kind    = KIND_EXPIRY;
            e.slot_id = SlotW'(i);
            e.status  = STAT_OK;
            e.last    = 1'b0;
            batch.push_back(e);
          end
        end
        if (batch.size() > 0) begin
          e = batch.pop_back();
          e.last = 1'b1;
          batch.push_back(e);
        end
        expiries += batch.size();
        foreach (batch[k]) pending_events_q.push_back(batch[k]);
        return;
      end
      e.kind    = KIND_STATUS;
      e.slot_id = r.slot;
      e.status  = STAT_OK;
      e.last    = 1'b1;
      case (cmd_e'(r.cmd))
        CMD_START: begin
          if (armed[s]) begin
            e.status = STAT_ACTIVE;
          end else begin
            due_at[s] = tick_now + {1'b0, r.timeout};
            period[s] = r.repeat_req;
            armed[s]  = 1'b1;
          end
        end
        CMD_CHANGE: begin
          due_at[s] = tick_now + {1'b0, r.timeout};
          period[s] = '0;
          if (armed[s]) e.status = STAT_ACTIVE;
          armed[s] = 1'b1;
        end
        default: armed[s] = 1'b0;
      endcase
      if (e.status == STAT_ACTIVE) busy_reports++;
      pending_events_q.push_back(e);
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (pending_events_q.size() == 0) begin
        note_failure($sformatf("unexpected result %s", fmt(got)));
        return;
      end
      want = pending_events_q.pop_front();
      results_seen++;
      if (got.kind !== want.kind || got.slot_id !== want.slot_id ||
          got.status !== want.status || got.last !== want.last)
        note_failure($sformatf("expected %s, got %s", fmt(want), fmt(got)));
    endfunction
  endclass

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic req_valid_i = 1'b0;
  logic req_ready_o;
  req_t req_i       = '0;
  logic rsp_valid_o;
  logic rsp_ready_i = 1'b0;
  rsp_t rsp_o;

  timer_bank_board sb = new();
  int sender_idle_pct = 0;
  int stall_pct       = 0;
  int quiet_cycles    = 0;

  multi_slot_software_timer_top #(
    .NUM_TIMERS(NumSlots)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid_i),
    .req_ready_o(req_ready_o),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_ready_i(rsp_ready_i),
    .rsp_o      (rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    rsp_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_valid_i && req_ready_o) sb.note_request(req_i);
      if (rsp_valid_o && rsp_ready_i) sb.check_result(rsp_o);
      if ((req_valid_i && req_ready_o) || (rsp_valid_o && rsp_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("watchdog: no handshake for %0d cycles", QuietLimit);
        $display("tb_multi_slot_software_timer_top NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_request(input req_t r);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      req_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i       <= r;
    do @(posedge clk_i); while (!req_ready_o);
  endtask

  task automatic issue(input cmd_e c, input int s, input logic [ReloadW-1:0] tmo,
                       input logic [ReloadW-1:0] rep);
    req_t r;
    r.cmd        = c;
    r.slot       = SlotW'(s);
    r.timeout    = tmo;
    r.repeat_req = rep;
    send_request(r);
  endtask

  task automatic wait_drained();
    req_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  function automatic req_t random_request();
    req_t        r;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 45)      r.cmd = CMD_TICK;
    else if (pick < 70) r.cmd = CMD_START;
    else if (pick < 85) r.cmd = CMD_CHANGE;
    else                r.cmd = CMD_STOP;
    r.slot = SlotW'($urandom_range(NumSlots - 1));
    if ($urandom_range(9) == 0) r.timeout = ReloadW'($urandom);
    else r.timeout = ReloadW'($urandom_range(12));
    if ($urandom_range(9) == 0) r.repeat_req = ReloadW'($urandom);
    else if ($urandom_range(2) == 0) r.repeat_req = '0;
    else r.repeat_req = ReloadW'($urandom_range(8));
    return r;
  endfunction

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue(CMD_TICK, 0, '0, '0);
    issue(CMD_START, 0, '0, '0);
    issue(CMD_START, 0, '1, '1);
    issue(CMD_START, 15, '1, '1);
    issue(CMD_START, 3, 31'd1, 31'd2);
    issue(CMD_CHANGE, 5, 31'd2, '1);
    issue(CMD_CHANGE, 5, '0, '0);
    issue(CMD_TICK, 0, '1, '1);
    issue(CMD_STOP, 15, '0, '0);
    issue(CMD_STOP, 15, '1, '1);
    for (int i = 0; i < NumSlots; i++) issue(CMD_CHANGE, i, '0, '1);
    issue(CMD_TICK, 0, '0, '0);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 48; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 48; end
        default: begin sender_idle_pct = 35; stall_pct = 35; end
      endcase
      for (int n = 0; n < 81; n++) send_request(random_request());
      wait_drained();
    end

    repeat (TailCycles) @(posedge clk_i);
    $display("covered %0d requests (%0d ticks), %0d results checked", sb.requests,
             sb.ticks, sb.results_seen);
    $display("  including %0d expiries and %0d already-active reports, four stall mixes",
             sb.expiries, sb.busy_reports);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("tb_multi_slot_software_timer_top OK");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.failures, sb.pending());
      $display("tb_multi_slot_software_timer_top NOT OK");
    end
    $finish;
  end

endmodule

### files.f
rtl/mst_pkg.sv
rtl/mst_mem.sv
rtl/mst_ctrl.sv
rtl/multi_slot_software_timer_top.sv
test/tb_multi_slot_software_timer_top.sv
